>>> rtl/glvg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package glvg_pkg;

  localparam int unsigned DefMaxOrder = 31;
  localparam int unsigned FracBits    = 24;
  localparam int unsigned ValW        = 64;
  localparam int unsigned AccW        = 128;
  localparam int unsigned PcW         = 5;

  localparam logic [ValW-1:0] ONE_Q = 64'd1 << FracBits;

  localparam logic [1:0] K_TERM  = 2'd0;
  localparam logic [1:0] K_DIV   = 2'd1;
  localparam logic [1:0] K_CHECK = 2'd2;
  localparam logic [1:0] K_NEXT  = 2'd3;

  localparam logic [3:0] S_X   = 4'd0;
  localparam logic [3:0] S_A1  = 4'd1;
  localparam logic [3:0] S_A2  = 4'd2;
  localparam logic [3:0] S_A3  = 4'd3;
  localparam logic [3:0] S_XX  = 4'd4;
  localparam logic [3:0] S_PP  = 4'd5;
  localparam logic [3:0] S_LN  = 4'd6;
  localparam logic [3:0] S_LM  = 4'd7;
  localparam logic [3:0] S_GN  = 4'd8;
  localparam logic [3:0] S_GM  = 4'd9;
  localparam logic [3:0] S_C   = 4'd10;
  localparam logic [3:0] S_D   = 4'd11;
  localparam logic [3:0] S_ONE = 4'd12;

  localparam logic [2:0] D_LM = 3'd0;
  localparam logic [2:0] D_XX = 3'd1;
  localparam logic [2:0] D_PP = 3'd2;
  localparam logic [2:0] D_LN = 3'd3;
  localparam logic [2:0] D_GN = 3'd4;
  localparam logic [2:0] D_NL = 3'd5;
  localparam logic [2:0] D_NG = 3'd6;

  localparam logic [1:0] V_ONE = 2'd0;
  localparam logic [1:0] V_TWO = 2'd1;
  localparam logic [1:0] V_SIX = 2'd2;
  localparam logic [1:0] V_I1  = 2'd3;

  localparam logic [PcW-1:0] CHECK_PC = 5'd23;
  localparam logic [PcW-1:0] LOOP_PC  = 5'd24;

  typedef struct packed {
    logic [1:0] kind;
    logic [3:0] src_a;
    logic [3:0] src_b;
    logic       neg;
    logic [2:0] dst;
    logic [1:0] dvs;
  } op_t;

  typedef struct packed {
    logic            go;
    logic            neg;
    logic [ValW-1:0] a;
    logic [ValW-1:0] b;
  } mul_cmd_t;

  typedef struct packed {
    logic            go;
    logic [AccW-1:0] s;
  } div_cmd_t;

  function automatic op_t term(input logic [3:0] a, input logic [3:0] b, input logic n);
    op_t o;
    o = '{kind: K_TERM, src_a: a, src_b: b, neg: n, dst: D_LM, dvs: V_ONE};
    return o;
  endfunction

  function automatic op_t dv(input logic [1:0] v, input logic [2:0] d);
    op_t o;
    o = '{kind: K_DIV, src_a: S_X, src_b: S_X, neg: 1'b0, dst: d, dvs: v};
    return o;
  endfunction

  function automatic op_t prog_rom(input logic [PcW-1:0] pc);
    op_t o;
    unique case (pc)
      5'd0:  o = term(S_X, S_X, 1'b0);
      5'd1:  o = term(S_A2, S_X, 1'b1);
      5'd2:  o = term(S_A2, S_X, 1'b1);
      5'd3:  o = term(S_A1, S_A2, 1'b0);
      5'd4:  o = dv(V_TWO, D_LM);
      5'd5:  o = term(S_X, S_X, 1'b0);
      5'd6:  o = dv(V_ONE, D_XX);
      5'd7:  o = term(S_A2, S_A3, 1'b0);
      5'd8:  o = dv(V_ONE, D_PP);
      5'd9:  o = term(S_A3, S_XX, 1'b0);
      5'd10: o = term(S_A3, S_XX, 1'b0);
      5'd11: o = term(S_A3, S_XX, 1'b0);
      5'd12: o = term(S_X, S_XX, 1'b1);
      5'd13: o = term(S_PP, S_X, 1'b1);
      5'd14: o = term(S_PP, S_X, 1'b1);
      5'd15: o = term(S_PP, S_X, 1'b1);
      5'd16: o = term(S_A1, S_PP, 1'b0);
      5'd17: o = dv(V_SIX, D_LN);
      5'd18: o = term(S_A3, S_X, 1'b0);
      5'd19: o = term(S_A3, S_X, 1'b0);
      5'd20: o = term(S_X, S_X, 1'b1);
      5'd21: o = term(S_A2, S_A3, 1'b1);
      5'd22: o = dv(V_TWO, D_GN);
      5'd23: o = '{kind: K_CHECK, src_a: S_X, src_b: S_X, neg: 1'b0, dst: D_LM, dvs: V_ONE};
      5'd24: o = term(S_C, S_LN, 1'b0);
      5'd25: o = term(S_D, S_LM, 1'b1);
      5'd26: o = dv(V_I1, D_NL);
      5'd27: o = term(S_C, S_GN, 1'b0);
      5'd28: o = term(S_LN, S_ONE, 1'b1);
      5'd29: o = term(S_D, S_GM, 1'b1);
      5'd30: o = dv(V_I1, D_NG);
      default: o = '{kind: K_NEXT, src_a: S_X, src_b: S_X, neg: 1'b0, dst: D_LM, dvs: V_ONE};
    endcase
    return o;
  endfunction

endpackage
`default_nettype wire

>>> rtl/glvg_mul_serial.sv
`timescale 1ns / 1ps
`default_nettype none
module glvg_mul_serial (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire glvg_pkg::mul_cmd_t        cmd,
  input  wire logic                      acc_clr,
  output logic [glvg_pkg::AccW-1:0]      acc,
  output logic                           busy
);
  import glvg_pkg::*;

  logic [AccW-1:0] ma_r, acc_r;
  logic [ValW-1:0] mb_r;
  logic            sub_r, busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (cmd.go) begin
      busy_r <= 1'b1;
    end else if (busy_r && (mb_r[ValW-1:1] == '0)) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc_clr) begin
      acc_r <= '0;
    end else if (busy_r && mb_r[0]) begin
      acc_r <= sub_r ? acc_r - ma_r : acc_r + ma_r;
    end
    if (cmd.go) begin
      ma_r  <= {{(AccW-ValW){cmd.a[ValW-1]}}, cmd.a};
      mb_r  <= cmd.b[ValW-1] ? (~cmd.b + ValW'(1)) : cmd.b;
      sub_r <= cmd.neg ^ cmd.b[ValW-1];
    end else if (busy_r) begin
      ma_r <= {ma_r[AccW-2:0], 1'b0};
      mb_r <= {1'b0, mb_r[ValW-1:1]};
    end
  end

  assign acc  = acc_r;
  assign busy = busy_r;
endmodule
`default_nettype wire

>>> rtl/glvg_div_serial.sv
`timescale 1ns / 1ps
`default_nettype none
module glvg_div_serial #(
  parameter int unsigned DW = 29
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire glvg_pkg::div_cmd_t        cmd,
  input  wire logic [DW-1:0]             divisor,
  output logic [glvg_pkg::ValW-1:0]      quot,
  output logic                           ovf,
  output logic                           busy
);
  import glvg_pkg::*;

  logic [AccW-1:0] m_r, mag;
  logic [DW-1:0]   rem_r, d_r;
  logic [ValW-1:0] q_r;
  logic            hi_r, neg_r, busy_r;
  logic [6:0]      cnt_r;
  logic [DW:0]     trial, diff;
  logic            ge;

  assign mag   = cmd.s[AccW-1] ? (~cmd.s + AccW'(1)) : cmd.s;
  assign trial = {rem_r, m_r[AccW-1]};
  assign diff  = trial - {1'b0, d_r};
  assign ge    = trial >= {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (cmd.go) begin
      busy_r <= 1'b1;
    end else if (busy_r && (cnt_r == 7'd127)) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.go) begin
      neg_r <= cmd.s[AccW-1];
      m_r   <= mag + {{(AccW-DW+1){1'b0}}, divisor[DW-1:1]};
      d_r   <= divisor;
      rem_r <= '0;
      q_r   <= '0;
      hi_r  <= 1'b0;
      cnt_r <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? diff[DW-1:0] : trial[DW-1:0];
      q_r   <= {q_r[ValW-2:0], ge};
      hi_r  <= hi_r | q_r[ValW-1];
      m_r   <= {m_r[AccW-2:0], 1'b0};
      cnt_r <= cnt_r + 7'd1;
    end
  end

  always_comb begin
    if (neg_r) begin
      if (hi_r || (q_r[ValW-1] && (q_r[ValW-2:0] != '0))) begin
        ovf  = 1'b1;
        quot = {1'b1, {(ValW-1){1'b0}}};
      end else begin
        ovf  = 1'b0;
        quot = ~q_r + ValW'(1);
      end
    end else if (hi_r || q_r[ValW-1]) begin
      ovf  = 1'b1;
      quot = {1'b0, {(ValW-1){1'b1}}};
    end else begin
      ovf  = 1'b0;
      quot = q_r;
    end
  end

  assign busy = busy_r;
endmodule
`default_nettype wire

>>> rtl/gen_laguerre_value_gradient_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Generalised Laguerre value and gradient unit.
// Command port: present in_x_point (unsigned Q8.24) and in_poly_order with start
// high while busy is low; the transaction is taken at that edge and busy rises.
// Result: out_poly_value, out_poly_gradient (signed Q40.24, saturated) and
// out_overflow are shown for one cycle with out_valid; busy falls with it.
// cfg_wr_en/cfg_wr_data write alpha (signed Q8.24); the user must do so only
// while busy is low; the unit does not enforce it. Orders above MAX_ORDER are
// clamped to MAX_ORDER. For orders 0 and 1 the taking edge moves the unit from
// idle straight to the output state, and out_valid rises at the next edge.
// Higher orders run a microprogram on a bit-serial shift-add multiplier (one
// multiplier bit a cycle, stopping at the top set bit) and a restoring divider.
// Orders 2 and 3 need 18 terms and 5 divisions; each further order adds 5 terms
// and 2 divisions.
// The next transaction can be taken at the edge that ends the out_valid cycle.
// Reset (synchronous, rst_n low) clears alpha to 0 and returns to idle.
// The receiver cannot stall: each result is valid for exactly one cycle.
module gen_laguerre_value_gradient_unit #(
  parameter int unsigned MAX_ORDER = glvg_pkg::DefMaxOrder
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic [31:0]               in_x_point,
  input  wire logic [4:0]                in_poly_order,
  output logic                           out_valid,
  output logic signed [63:0]             out_poly_value,
  output logic signed [63:0]             out_poly_gradient,
  output logic                           out_overflow,
  input  wire logic                      cfg_wr_en,
  input  wire logic signed [31:0]        cfg_wr_data
);
  import glvg_pkg::*;

  localparam int unsigned NW = $clog2(MAX_ORDER + 1);
  localparam int unsigned DW = ((NW > 3) ? NW : 3) + FracBits;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RUN  = 3'd1;
  localparam logic [2:0] ST_MUL  = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  logic [2:0]      state_r;
  logic [PcW-1:0]  pc_r;
  logic [NW-1:0]   n_r, i_r, n_eff, i_inc;
  logic            ov_r, valid_r;
  logic [31:0]     alpha_r;
  logic [ValW-1:0] x_r, xx_r, pp_r, lm_r, ln_r, gm_r, gn_r, nl_r, ng_r;
  logic [ValW-1:0] a_ext, a1, a2, a3, c_w, d_w, opa, opb;
  logic [ValW-1:0] val_r, grad_r;
  logic [DW-1:0]   divisor;
  logic [AccW-1:0] acc;
  logic [ValW-1:0] quot;
  logic            dv_ovf, mul_busy, div_busy, acc_clr;
  mul_cmd_t        mcmd;
  div_cmd_t        dcmd;
  op_t             op;

  assign op    = prog_rom(pc_r);
  assign a_ext = {{(ValW-32){alpha_r[31]}}, alpha_r};
  assign a1    = a_ext + ONE_Q;
  assign a2    = a_ext + (ONE_Q << 1);
  assign a3    = a_ext + (ONE_Q << 1) + ONE_Q;
  assign i_inc = i_r + NW'(1);
  assign c_w   = ({{(ValW-NW-1){1'b0}}, i_r, 1'b1} << FracBits) + a_ext - x_r;
  assign d_w   = ({{(ValW-NW){1'b0}}, i_r} << FracBits) + a_ext;

  always_comb begin
    if ({27'd0, in_poly_order} > 32'(MAX_ORDER)) n_eff = NW'(MAX_ORDER);
    else n_eff = NW'(in_poly_order);
  end

  function automatic logic [ValW-1:0] pick(input logic [3:0] s,
      input logic [ValW-1:0] x, input logic [ValW-1:0] b1,
      input logic [ValW-1:0] b2, input logic [ValW-1:0] b3,
      input logic [ValW-1:0] xx, input logic [ValW-1:0] pp,
      input logic [ValW-1:0] ln, input logic [ValW-1:0] lm,
      input logic [ValW-1:0] gn, input logic [ValW-1:0] gm,
      input logic [ValW-1:0] c, input logic [ValW-1:0] d);
    logic [ValW-1:0] r;
    unique case (s)
      S_X:   r = x;
      S_A1:  r = b1;
      S_A2:  r = b2;
      S_A3:  r = b3;
      S_XX:  r = xx;
      S_PP:  r = pp;
      S_LN:  r = ln;
      S_LM:  r = lm;
      S_GN:  r = gn;
      S_GM:  r = gm;
      S_C:   r = c;
      S_D:   r = d;
      default: r = ONE_Q;
    endcase
    return r;
  endfunction

  assign opa = pick(op.src_a, x_r, a1, a2, a3, xx_r, pp_r, ln_r, lm_r, gn_r, gm_r,
                    c_w, d_w);
  assign opb = pick(op.src_b, x_r, a1, a2, a3, xx_r, pp_r, ln_r, lm_r, gn_r, gm_r,
                    c_w, d_w);

  always_comb begin
    unique case (op.dvs)
      V_ONE:   divisor = DW'(ONE_Q);
      V_TWO:   divisor = DW'(ONE_Q << 1);
      V_SIX:   divisor = DW'(ONE_Q * 6);
      default: divisor = DW'({i_inc, {FracBits{1'b0}}});
    endcase
  end

  assign mcmd.go  = (state_r == ST_RUN) && (op.kind == K_TERM);
  assign mcmd.neg = op.neg;
  assign mcmd.a   = opa;
  assign mcmd.b   = opb;
  assign dcmd.go  = (state_r == ST_RUN) && (op.kind == K_DIV);
  assign dcmd.s   = acc;
  assign acc_clr  = dcmd.go || (start && !busy);

  glvg_mul_serial u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (mcmd),
    .acc_clr (acc_clr),
    .acc     (acc),
    .busy    (mul_busy)
  );

  glvg_div_serial #(.DW(DW)) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (dcmd),
    .divisor (divisor),
    .quot    (quot),
    .ovf     (dv_ovf),
    .busy    (div_busy)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r <= '0;
    end else if (cfg_wr_en) begin
      alpha_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      valid_r <= 1'b0;
      pc_r    <= '0;
    end else begin
      valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (start) begin
            pc_r    <= '0;
            state_r <= (n_eff < NW'(2)) ? ST_OUT : ST_RUN;
          end
        end
        ST_RUN: begin
          unique case (op.kind)
            K_TERM:  state_r <= ST_MUL;
            K_DIV:   state_r <= ST_DIV;
            K_CHECK: begin
              if (i_r < n_r) pc_r <= LOOP_PC;
              else state_r <= ST_OUT;
            end
            default: pc_r <= CHECK_PC;
          endcase
        end
        ST_MUL: begin
          if (!mul_busy) begin
            pc_r    <= pc_r + PcW'(1);
            state_r <= ST_RUN;
          end
        end
        ST_DIV: begin
          if (!div_busy) begin
            pc_r    <= pc_r + PcW'(1);
            state_r <= ST_RUN;
          end
        end
        ST_OUT: begin
          valid_r <= 1'b1;
          state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && start) begin
      x_r  <= {32'd0, in_x_point};
      n_r  <= n_eff;
      i_r  <= NW'(3);
      ov_r <= 1'b0;
      gm_r <= {32'd0, in_x_point} - a2;
    end
    if (state_r == ST_DIV && !div_busy) begin
      ov_r <= ov_r | dv_ovf;
      unique case (op.dst)
        D_LM:    lm_r <= quot;
        D_XX:    xx_r <= quot;
        D_PP:    pp_r <= quot;
        D_LN:    ln_r <= quot;
        D_GN:    gn_r <= quot;
        D_NL:    nl_r <= quot;
        default: ng_r <= quot;
      endcase
    end
    if (state_r == ST_RUN && op.kind == K_NEXT) begin
      lm_r <= ln_r;
      ln_r <= nl_r;
      gm_r <= gn_r;
      gn_r <= ng_r;
      i_r  <= i_inc;
    end
    if (state_r == ST_OUT) begin
      unique case (n_r)
        NW'(0): begin
          val_r  <= ONE_Q;
          grad_r <= '0;
        end
        NW'(1): begin
          val_r  <= a1 - x_r;
          grad_r <= ~ONE_Q + ValW'(1);
        end
        NW'(2): begin
          val_r  <= lm_r;
          grad_r <= gm_r;
        end
        default: begin
          val_r  <= ln_r;
          grad_r <= gn_r;
        end
      endcase
    end
  end

  assign busy              = (state_r != ST_IDLE);
  assign out_valid         = valid_r;
  assign out_poly_value    = val_r;
  assign out_poly_gradient = grad_r;
  assign out_overflow      = ov_r;

`ifndef SYNTH
  a_valid_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");
  a_units_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(mul_busy && div_busy))
    else $error("multiplier and divider active together");
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    !busy |-> (!mul_busy && !div_busy))
    else $error("arithmetic unit active while idle");
  a_take: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("transaction taken without going busy");
`endif
endmodule
`default_nettype wire

>>> dv/gen_laguerre_value_gradient_unit_tb.sv
`timescale 1ns / 1ps
module gen_laguerre_value_gradient_unit_tb;
  import glvg_pkg::*;

  localparam int unsigned MaxOrder = 31;
  localparam logic signed [63:0] OneQ = 64'sd1 <<< 24;
  localparam logic signed [63:0] SatMax = 64'sh7fff_ffff_ffff_ffff;
  localparam logic signed [63:0] SatMin = 64'sh8000_0000_0000_0000;
  localparam longint unsigned CycleLimit = 64'd60_000_000;

  typedef struct {
    logic signed [63:0] value;
    logic signed [63:0] gradient;
    logic               ovf;
  } poly_result_t;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic [31:0] in_x_point;
  logic [4:0] in_poly_order;
  logic out_valid;
  logic signed [63:0] out_poly_value;
  logic signed [63:0] out_poly_gradient;
  logic out_overflow;
  logic cfg_wr_en;
  logic signed [31:0] cfg_wr_data;

  logic signed [31:0] alpha_q;
  poly_result_t pending_results[$];
  int unsigned mismatches;
  longint unsigned cycles;
  bit idle_en;

  gen_laguerre_value_gradient_unit #(.MAX_ORDER(MaxOrder)) uut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_x_point(in_x_point),
    .in_poly_order(in_poly_order),
    .out_valid(out_valid),
    .out_poly_value(out_poly_value),
    .out_poly_gradient(out_poly_gradient),
    .out_overflow(out_overflow),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic signed [127:0] wide_mul(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
    logic signed [127:0] wa;
    logic signed [127:0] wb;
    wa = a;
    wb = b;
    return wa * wb;
  endfunction

  function automatic logic signed [63:0] round_div(input logic signed [127:0] s,
                                                   input logic [63:0] d,
                                                   inout logic ovf);
    logic [127:0] m;
    logic [127:0] q;
    logic neg;
    neg = s[127];
    m = neg ? -s : s;
    m = m + {64'd0, d >> 1};
    q = m / {64'd0, d};
    if (neg) begin
      if (q > (128'd1 << 63)) begin
        ovf = 1'b1;
        return SatMin;
      end
      return -$signed(q[63:0]);
    end
    if (q > 128'h7fff_ffff_ffff_ffff) begin
      ovf = 1'b1;
      return SatMax;
    end
    return $signed(q[63:0]);
  endfunction

  function automatic poly_result_t laguerre_eval(input logic [31:0] x_pt,
                                                 input logic [4:0] order_in,
                                                 input logic signed [31:0] alpha_in);
    poly_result_t r;
    logic signed [63:0] x, a, a1, a2, a3, xx, pp, c, d;
    logic signed [63:0] l2, l3, g2, g3, ln, lm, gn, gm, nl, ng;
    logic signed [127:0] s;
    logic ovf;
    int unsigned n;
    x = {32'd0, x_pt};
    a = alpha_in;
    a1 = a + OneQ;
    a2 = a + 2 * OneQ;
    a3 = a + 3 * OneQ;
    ovf = 1'b0;
    n = order_in;
    if (n > MaxOrder) n = MaxOrder;
    s = wide_mul(x, x) - 2 * wide_mul(a2, x) + wide_mul(a1, a2);
    l2 = round_div(s, 64'(2 * OneQ), ovf);
    g2 = x - a2;
    xx = round_div(wide_mul(x, x), 64'(OneQ), ovf);
    pp = round_div(wide_mul(a2, a3), 64'(OneQ), ovf);
    s = 3 * wide_mul(a3, xx) - wide_mul(x, xx) - 3 * wide_mul(pp, x) + wide_mul(a1, pp);
    l3 = round_div(s, 64'(6 * OneQ), ovf);
    s = 2 * wide_mul(a3, x) - wide_mul(x, x) - wide_mul(a2, a3);
    g3 = round_div(s, 64'(2 * OneQ), ovf);
    case (n)
      0: begin
        r.value = OneQ;
        r.gradient = 0;
      end
      1: begin
        r.value = a1 - x;
        r.gradient = -OneQ;
      end
      2: begin
        r.value = l2;
        r.gradient = g2;
      end
      default: begin
        ln = l3;
        lm = l2;
        gn = g3;
        gm = g2;
        for (int unsigned i = 3; i < n; i++) begin
          c = 64'(2 * i + 1) * OneQ + a - x;
          d = 64'(i) * OneQ + a;
          s = wide_mul(c, ln) - wide_mul(d, lm);
          nl = round_div(s, 64'(i + 1) << 24, ovf);
          s = wide_mul(c, gn) - wide_mul(ln, OneQ) - wide_mul(d, gm);
          ng = round_div(s, 64'(i + 1) << 24, ovf);
          lm = ln;
          ln = nl;
          gm = gn;
          gn = ng;
        end
        r.value = ln;
        r.gradient = gn;
      end
    endcase
    r.ovf = ovf;
    return r;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("gen_laguerre_value_gradient_unit_tb failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    poly_result_t exp_r;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: value %h gradient %h",
                                       out_poly_value, out_poly_gradient);
      end else begin
        exp_r = pending_results.pop_front();
        if (out_poly_value !== exp_r.value || out_poly_gradient !== exp_r.gradient ||
            out_overflow !== exp_r.ovf) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp %h %h %b, got %h %h %b", exp_r.value, exp_r.gradient,
                     exp_r.ovf, out_poly_value, out_poly_gradient, out_overflow);
        end
      end
    end
  end

  task automatic send_point(input logic [31:0] x_pt, input logic [4:0] order);
    start = 1'b1;
    in_x_point = x_pt;
    in_poly_order = order;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    pending_results.push_back(laguerre_eval(x_pt, order, alpha_q));
    @(negedge clk);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      start = 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
  endtask

  task automatic drain;
    start = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (5) @(negedge clk);
  endtask

  task automatic write_alpha(input logic signed [31:0] val);
    drain();
    cfg_wr_en = 1'b1;
    cfg_wr_data = val;
    alpha_q = val;
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  function automatic logic [4:0] rand_order;
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 60) return 5'($urandom_range(0, 1));
    if (p < 90) return 5'($urandom_range(2, 5));
    if (p < 98) return 5'($urandom_range(6, 12));
    return 5'($urandom_range(13, 31));
  endfunction

  function automatic logic [31:0] rand_point;
    if ($urandom_range(0, 1)) return $urandom_range(0, 32'd40 << 24);
    return $urandom;
  endfunction

  task automatic test_directed;
    write_alpha(32'sd0);
    for (int k = 0; k < 6; k++) send_point(32'd0, 5'(k));
    send_point(32'hffff_ffff, 5'd31);
    send_point(32'd1 << 24, 5'd31);
    send_point(32'd3 << 23, 5'd4);
    write_alpha(32'sh7fff_ffff);
    send_point(32'd0, 5'd3);
    send_point(32'hffff_ffff, 5'd31);
    send_point(32'h0000_0001, 5'd2);
    write_alpha(-32'sd16777215);
    send_point(32'd0, 5'd2);
    send_point(32'd1 << 24, 5'd4);
    send_point(32'h8000_0000, 5'd1);
    write_alpha(-32'sd16777216);
    send_point(32'd2 << 24, 5'd5);
    write_alpha(32'sh8000_0000);
    send_point(32'd5 << 24, 5'd3);
    send_point(32'h5555_5555, 5'd0);
  endtask

  task automatic test_alpha_settings;
    logic signed [31:0] settings[5];
    settings = '{32'sd1 << 24, -32'sd8388608, 32'sd5 << 24, 32'sh7fff_ffff, -32'sd16777215};
    foreach (settings[k]) begin
      write_alpha(settings[k]);
      repeat (40) send_point(rand_point(), rand_order());
    end
  endtask

  task automatic test_random(input int unsigned count);
    for (int unsigned k = 0; k < count; k++) begin
      if (k % 150 == 0) write_alpha($signed($urandom_range(0, 32'd20 << 24)) - 32'sd16777215);
      send_point(rand_point(), rand_order());
    end
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_x_point = '0;
    in_poly_order = '0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    alpha_q = '0;
    mismatches = 0;
    cycles = 0;
    idle_en = 1'b1;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_alpha_settings();
    test_random(700);
    idle_en = 1'b0;
    test_random(200);
    drain();
    repeat (20) @(negedge clk);
    if (mismatches == 0) begin
      $display("gen_laguerre_value_gradient_unit_tb passed");
    end else begin
      $display("gen_laguerre_value_gradient_unit_tb failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/glvg_pkg.sv
rtl/glvg_mul_serial.sv
rtl/glvg_div_serial.sv
rtl/gen_laguerre_value_gradient_unit.sv
dv/gen_laguerre_value_gradient_unit_tb.sv
